[src/s2d_pkg.sv]
// Shared types and constants for the signed binary to decimal ASCII converter.
package s2d_pkg;

    // Magnitude width and decimal digit layout
    localparam int MAG_W         = 64;
    localparam int DIGIT_W       = 4;
    localparam int DIGITS        = 20;
    localparam int BCD_W         = DIGITS * DIGIT_W;
    localparam int CNT_W         = $clog2(DIGITS + 1);
    localparam int IDX_W         = $clog2(DIGITS);

    // Double dabble: bits shifted in per step, and the resulting step count
    localparam int BITS_PER_STEP = 4;
    localparam int STEPS         = MAG_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(STEPS);

    // Character codes
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [3:0] DIGIT_NINE  = 4'd9;

    // One classified number: sign and unsigned magnitude
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } s2d_item_t;

    // Converted number handed to the emitter
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
        logic [CNT_W-1:0] ndig;
    } s2d_digits_t;

endpackage

[src/signed_binary_to_decimal_ascii.sv]
// Top level: signed 64-bit integer to decimal ASCII character stream.
//
//  Channel   Handshake        Payload                    Direction
//  input     push / full      value[63:0] signed         in
//  result    empty / pop      character[7:0], last       out
//
//  A number passes a registered front stage and a two-entry queue, then the
//  converter loads it and runs double dabble steps of 4 bits each. The emitter
//  sends one character per cycle while the result is popped; the converter works
//  on the next number while the emitter sends the current one.
//  Reset clears all control state; the block is ready on the first cycle.
//  A stalled result (pop low) holds the emitter; input keeps flowing until the
//  front stage and queue fill, then full rises.
module signed_binary_to_decimal_ascii
    import s2d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [63:0] value,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         character,
    output logic               last
);

    logic        q_push;
    logic        q_full;
    s2d_item_t   q_wr_item;
    logic        q_pop;
    logic        q_valid;
    s2d_item_t   q_rd_item;
    logic        conv_valid;
    logic        conv_take;
    s2d_digits_t conv_out;

    s2d_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .value  (value),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_wr_item)
    );

    s2d_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (q_wr_item),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_valid (q_valid),
        .rd_item (q_rd_item)
    );

    s2d_conv u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_rd_item),
        .q_pop      (q_pop),
        .conv_valid (conv_valid),
        .conv_out   (conv_out),
        .conv_take  (conv_take)
    );

    s2d_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .conv_valid (conv_valid),
        .conv_out   (conv_out),
        .conv_take  (conv_take),
        .empty      (empty),
        .pop        (pop),
        .character  (character),
        .last       (last)
    );

    // Queue is never written while full
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("queue write while full");

    // Emitter takes a converted number only when one is offered
    assert property (@(posedge clk) disable iff (!rst_n) conv_take |-> conv_valid)
        else $error("emitter took without a converted number");

    // Converter only dequeues when the queue holds an item
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("dequeue from empty queue");

    // The sign is never the last character of a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(last && (character == ASCII_MINUS)))
        else $error("minus sign marked as last character");

    // Every result character is a digit or the minus sign
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((character == ASCII_MINUS) ||
                    ((character >= ASCII_ZERO) &&
                     (character <= (ASCII_ZERO + {4'd0, DIGIT_NINE})))))
        else $error("result character out of range");

endmodule

[src/s2d_front.sv]
// Front end: takes a number, splits it into sign and unsigned magnitude.
module s2d_front
    import s2d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [63:0] value,
    input  logic               q_full,
    output logic               q_push,
    output s2d_item_t          q_item
);

    logic      stage_valid_reg;
    logic      stage_valid_next;
    s2d_item_t stage_reg;
    logic      accept;
    logic      neg;

    // A held item blocks new input only while the queue is full
    assign full   = stage_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = stage_valid_reg && !q_full;
    assign q_item = stage_reg;

    // Magnitude in unsigned form, exact for the most negative value
    assign neg = value[63];

    always_comb
    begin
        stage_valid_next = (stage_valid_reg && q_full) || accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.neg <= neg;
            stage_reg.mag <= neg ? (~value + 64'd1) : value;
        end
    end

endmodule

[src/s2d_queue.sv]
// Two-entry queue between the front end and the converter.
module s2d_queue
    import s2d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  s2d_item_t wr_item,
    output logic      q_full,
    input  logic      rd_en,
    output logic      q_valid,
    output s2d_item_t rd_item
);

    s2d_item_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_wr;
    logic        do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_item = entry_reg[rd_ptr_reg];

    // Occupancy tracking
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

[src/s2d_conv.sv]
// Back end converter: double dabble, four magnitude bits per cycle.
module s2d_conv
    import s2d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  s2d_item_t   q_item,
    output logic        q_pop,
    output logic        conv_valid,
    output s2d_digits_t conv_out,
    input  logic        conv_take
);

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_RUN,
        CV_DONE
    } conv_state_t;

    conv_state_t       state_reg;
    conv_state_t       state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              neg_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [BCD_W-1:0]  bcd_reg;
    logic [MAG_W-1:0]  mag_step;
    logic [BCD_W-1:0]  bcd_step;
    logic [CNT_W-1:0]  ndig;
    logic              load;

    // Shift-add-3 over all digits, repeated once per bit taken in
    always_comb
    begin
        bcd_step = bcd_reg;
        mag_step = mag_reg;
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (bcd_step[d*DIGIT_W +: DIGIT_W] > 4'd4)
                begin
                    bcd_step[d*DIGIT_W +: DIGIT_W] = bcd_step[d*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            bcd_step = {bcd_step[BCD_W-2:0], mag_step[MAG_W-1]};
            mag_step = {mag_step[MAG_W-2:0], 1'b0};
        end
    end

    // Significant digit count: highest nonzero digit, at least one for zero
    always_comb
    begin
        ndig = CNT_W'(1);
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[d*DIGIT_W +: DIGIT_W] != 4'd0)
            begin
                ndig = CNT_W'(d + 1);
            end
        end
    end

    assign conv_valid    = (state_reg == CV_DONE);
    assign conv_out.neg  = neg_reg;
    assign conv_out.bcd  = bcd_reg;
    assign conv_out.ndig = ndig;

    assign load  = q_valid && ((state_reg == CV_IDLE) || ((state_reg == CV_DONE) && conv_take));
    assign q_pop = load;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            CV_IDLE:
            begin
                if (load)
                begin
                    state_next = CV_RUN;
                    step_next  = '0;
                end
            end
            CV_RUN:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    state_next = CV_DONE;
                end
            end
            CV_DONE:
            begin
                if (load)
                begin
                    state_next = CV_RUN;
                    step_next  = '0;
                end
                else if (conv_take)
                begin
                    state_next = CV_IDLE;
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg <= q_item.neg;
            mag_reg <= q_item.mag;
            bcd_reg <= '0;
        end
        else if (state_reg == CV_RUN)
        begin
            mag_reg <= mag_step;
            bcd_reg <= bcd_step;
        end
    end

endmodule

[src/s2d_emit.sv]
// Back end emitter: sends sign and digits one character per cycle while the result is popped.
module s2d_emit
    import s2d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        conv_valid,
    input  s2d_digits_t conv_out,
    output logic        conv_take,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  character,
    output logic        last
);

    logic              sign_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [BCD_W-1:0]  bcd_reg;
    logic              out_valid_reg;
    logic [7:0]        char_reg;
    logic              last_reg;
    logic              busy;
    logic              gen;
    logic [CNT_W-1:0]  cnt_dec;
    logic [IDX_W-1:0]  idx;
    logic [3:0]        digit;
    logic [7:0]        char_next;
    logic              last_next;

    assign busy      = sign_reg || (cnt_reg != '0);
    assign conv_take = conv_valid && !busy;
    assign gen       = busy && (!out_valid_reg || pop);

    assign cnt_dec = cnt_reg - CNT_W'(1);
    assign idx     = cnt_dec[IDX_W-1:0];
    assign digit   = bcd_reg[idx*DIGIT_W +: DIGIT_W];

    // Next character: the sign first, then digits from the most significant
    always_comb
    begin
        if (sign_reg)
        begin
            char_next = ASCII_MINUS;
            last_next = 1'b0;
        end
        else
        begin
            char_next = ASCII_ZERO + {4'd0, digit};
            last_next = (cnt_reg == CNT_W'(1));
        end
    end

    assign empty     = !out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (conv_take)
            begin
                sign_reg <= conv_out.neg;
                cnt_reg  <= conv_out.ndig;
            end
            else if (gen)
            begin
                if (sign_reg)
                begin
                    sign_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_dec;
                end
            end
            if (gen)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Digit store and output register
    always_ff @(posedge clk)
    begin
        if (conv_take)
        begin
            bcd_reg <= conv_out.bcd;
        end
        if (gen)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

endmodule

[verif/signed_binary_to_decimal_ascii_test.sv]
// Testbench for signed_binary_to_decimal_ascii: directed corner and random 64-bit values checked against their text.
module signed_binary_to_decimal_ascii_test;
    import s2d_pkg::*;

    localparam int LIMIT_CYCLES   = 200000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_VALUES  = 90;
    localparam int QUIET_VALUES   = 30;

    // One expected character of a number's decimal text
    typedef struct packed {
        logic [7:0] code;
        logic       fin;
    } text_char_t;

    // Holds the decimal text still owed by the block and checks each character
    class decimal_text_scoreboard;
        text_char_t owed[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // Expand one accepted number into its characters, most significant first
        function void add_number(logic [63:0] v);
            logic [63:0] mag;
            logic [7:0]  digits [20];
            int          nd;
            int          i;
            mag = v[63] ? (~v + 64'd1) : v;
            nd  = 0;
            if (mag == 64'd0)
            begin
                owed.push_back('{ASCII_ZERO, 1'b1});
                return;
            end
            while (mag != 64'd0)
            begin
                digits[nd] = ASCII_ZERO + 8'(mag % 64'd10);
                nd++;
                mag = mag / 64'd10;
            end
            if (v[63])
                owed.push_back('{ASCII_MINUS, 1'b0});
            for (i = nd - 1; i >= 0; i--)
                owed.push_back('{digits[i], (i == 0)});
        endfunction

        task check_char(logic [7:0] code, logic fin);
            text_char_t want;
            if (owed.size() == 0)
            begin
                report($sformatf("unexpected character %h last %b", code, fin));
                return;
            end
            want = owed.pop_front();
            if (code !== want.code)
                report($sformatf("character %h, expected %h", code, want.code));
            if (fin !== want.fin)
                report($sformatf("last %b, expected %b on character %h",
                                 fin, want.fin, want.code));
        endtask

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n = 1'b0;
    logic               push  = 1'b0;
    logic               full;
    logic signed [63:0] value = '0;
    logic               empty;
    logic               pop   = 1'b0;
    logic [7:0]         character;
    logic               last;

    decimal_text_scoreboard sb = new();
    bit                     gaps_on   = 1'b1;
    bit                     hold_req  = 1'b0;
    int                     cycle_count = 0;

    signed_binary_to_decimal_ascii dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .empty     (empty),
        .pop       (pop),
        .character (character),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Transaction monitor and run limit; samples pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.add_number(value);
            if (pop && !empty)
                sb.check_char(character, last);
        end
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d characters owed",
                     cycle_count, sb.pending());
            $display("** signed_binary_to_decimal_ascii: FAILED **");
            $finish;
        end
    end

    // Offer one number and hold it until the block takes it
    task automatic send_value(input logic [63:0] v);
        push  <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (full);
    endtask

    // Optional random gap on the input side, then one number
    task automatic offer_value(input logic [63:0] v);
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        send_value(v);
    endtask

    function automatic logic [63:0] power_of_ten(input int k);
        logic [63:0] p;
        p = 64'd1;
        repeat (k) p = p * 64'd10;
        return p;
    endfunction

    // Random value: full-width patterns, small numbers, decade edges, random lengths
    function automatic logic [63:0] pick_value();
        logic [63:0] p;
        logic [63:0] v;
        p = power_of_ten($urandom_range(0, 18));
        case ($urandom_range(0, 3))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 1000));
            2: v = $urandom_range(0, 1) ? p : p - 64'd1;
            default: v = {$urandom, $urandom} % p;
        endcase
        if ($urandom_range(0, 1))
            v = ~v + 64'd1;
        return v;
    endfunction

    // Receiver: random pop bursts, one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [63:0] corner [20];
        int          n;
        corner = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd9, 64'd10,
                   -64'sd10, 64'd99, 64'd100, 64'h7FFF_FFFF_FFFF_FFFF,
                   64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
                   64'd1000000000000000000, 64'd999999999999999999,
                   -64'sd1000000000000000000, 64'd1234567890123456789,
                   -64'sd987654321, 64'hFFFF_FFFF, 64'h1_0000_0000,
                   64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners
        foreach (corner[i])
            offer_value(corner[i]);

        // Input keeps flowing while the receiver holds off
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        for (n = 0; n < RANDOM_VALUES; n++)
        begin
            if (n >= RANDOM_VALUES - QUIET_VALUES)
                gaps_on = 1'b0;
            else if (n >= 15 && n % 15 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            offer_value(pick_value());
        end
        push <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("** signed_binary_to_decimal_ascii: PASSED **");
        else
            $display("** signed_binary_to_decimal_ascii: FAILED **");
        $finish;
    end

endmodule
